// ===== sv/npmf_pkg.sv =====
// ----------------------------------------------------------------------------
// npmf_pkg
// Shared widths and constants of the near point merge filter.
// ----------------------------------------------------------------------------
package npmf_pkg;

  localparam int SPEED_BITS   = 24;
  localparam int ATTR_BITS    = 32;
  localparam int SPACING_BITS = 16;
  localparam int SQ_BITS      = 2 * SPACING_BITS;

  // A spacing of 10 mm, the 0.01 m merge threshold.
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 16'd10;
  localparam logic [SQ_BITS-1:0]      SPACING_SQ_RESET = 32'd100;

  // Result queue: one point may release two results at once.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== sv/npmf_point_if.sv =====
// ----------------------------------------------------------------------------
// npmf_point_if
// Valid/ready channel that carries one path point per word.
// ----------------------------------------------------------------------------
interface npmf_point_if import npmf_pkg::*; #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic signed [SPEED_BITS-1:0] speed;
  logic [ATTR_BITS-1:0]         attrs;
  logic                         last_point;

  modport source (output valid, pos_x, pos_y, pos_z, speed, attrs, last_point,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, speed, attrs, last_point,
                  output ready);
endinterface

// ===== sv/npmf_result_if.sv =====
// ----------------------------------------------------------------------------
// npmf_result_if
// Valid/ready channel that carries one kept point per word.
// ----------------------------------------------------------------------------
interface npmf_result_if import npmf_pkg::*; #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic signed [SPEED_BITS-1:0] out_speed;
  logic [ATTR_BITS-1:0]         out_attrs;
  logic                         out_last;

  modport source (output valid, out_x, out_y, out_z, out_speed, out_attrs, out_last,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_speed, out_attrs, out_last,
                  output ready);
endinterface

// ===== sv/npmf_distance.sv =====
// ----------------------------------------------------------------------------
// npmf_distance
// Planar far test of a point against the held point, exact integer math.
// ----------------------------------------------------------------------------
module npmf_distance import npmf_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] held_x,
  input  logic signed [COORD_BITS-1:0] held_y,
  input  logic [SPACING_BITS-1:0]      spacing,
  input  logic [SQ_BITS-1:0]           spacing_sq,
  output logic                         far
);
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        ax;
  logic [COORD_BITS:0]        ay;
  logic [COORD_BITS:0]        spacing_ext;
  logic                       axis_far;
  logic [SQ_BITS-1:0]         sq_x;
  logic [SQ_BITS-1:0]         sq_y;
  logic [SQ_BITS:0]           sq_sum;

  always_comb begin
    dx = {pos_x[COORD_BITS-1], pos_x} - {held_x[COORD_BITS-1], held_x};
    dy = {pos_y[COORD_BITS-1], pos_y} - {held_y[COORD_BITS-1], held_y};
    ax = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
    ay = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
    spacing_ext = (COORD_BITS+1)'(spacing);
    axis_far = (ax > spacing_ext) || (ay > spacing_ext);
    // The squares only matter when both offsets fit the spacing width.
    sq_x = ax[SPACING_BITS-1:0] * ax[SPACING_BITS-1:0];
    sq_y = ay[SPACING_BITS-1:0] * ay[SPACING_BITS-1:0];
    sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
    far = axis_far || (sq_sum > {1'b0, spacing_sq});
  end
endmodule

// ===== sv/near_point_merge_filter.sv =====
// ----------------------------------------------------------------------------
// near_point_merge_filter
// Thins a path by merging points that lie within the spacing of the held point.
// ----------------------------------------------------------------------------
// A point is registered in the input stage at acceptance and judged once the
// queue can take two results; its results are offered from the queue.
// Throughput: one point per cycle while the queue can take two results; the
// output moves one word per cycle, so a second result waits in the queue.
// Reset clears the held point, the input stage, the result queue and sets
// the spacing to 10 mm.
module near_point_merge_filter import npmf_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [SPACING_BITS-1:0] cfg_wr_data,
  npmf_point_if.sink              points,
  npmf_result_if.source           results
);
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic [SPEED_BITS-1:0] speed;
    logic [ATTR_BITS-1:0]  attrs;
    logic                  last;
  } entry_t;

  // Configuration.
  logic [SPACING_BITS-1:0] spacing;
  logic [SQ_BITS-1:0]      spacing_sq;

  // Input stage.
  logic                         in_valid;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;
  logic signed [SPEED_BITS-1:0] in_speed;
  logic [ATTR_BITS-1:0]         in_attrs;
  logic                         in_last;

  // Held point.
  logic                         held_valid;
  logic signed [COORD_BITS-1:0] held_x;
  logic signed [COORD_BITS-1:0] held_y;
  logic signed [COORD_BITS-1:0] held_z;
  logic signed [SPEED_BITS-1:0] held_speed;
  logic [ATTR_BITS-1:0]         held_attrs;
  logic                         held_valid_next;
  logic signed [COORD_BITS-1:0] held_x_next;
  logic signed [COORD_BITS-1:0] held_y_next;
  logic signed [COORD_BITS-1:0] held_z_next;
  logic signed [SPEED_BITS-1:0] held_speed_next;
  logic [ATTR_BITS-1:0]         held_attrs_next;

  // Result queue.
  entry_t              fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  logic       far;
  logic       proc_fire;
  logic       in_fire;
  logic       pop;
  logic       push_a;
  logic       push_b;
  logic [1:0] push_n;
  entry_t     ent_a;
  entry_t     ent_b;

  npmf_distance #(
    .COORD_BITS (COORD_BITS)
  ) u_distance (
    .pos_x      (in_x),
    .pos_y      (in_y),
    .held_x     (held_x),
    .held_y     (held_y),
    .spacing    (spacing),
    .spacing_sq (spacing_sq),
    .far        (far)
  );

  // A point is judged only when the queue can take both of its results.
  assign proc_fire = in_valid && (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign points.ready = !in_valid || proc_fire;
  assign in_fire = points.valid && points.ready;
  assign pop = results.valid && results.ready;

  always_comb begin
    held_valid_next = held_valid;
    held_x_next     = held_x;
    held_y_next     = held_y;
    held_z_next     = held_z;
    held_speed_next = held_speed;
    held_attrs_next = held_attrs;
    push_a = 1'b0;
    push_b = 1'b0;
    if (proc_fire) begin
      if (!held_valid || far) begin
        push_a = held_valid;
        held_valid_next = 1'b1;
        held_x_next     = in_x;
        held_y_next     = in_y;
        held_z_next     = in_z;
        held_speed_next = in_speed;
        held_attrs_next = in_attrs;
      end else if (in_speed < held_speed) begin
        held_speed_next = in_speed;
      end
      if (in_last) begin
        push_b = 1'b1;
        held_valid_next = 1'b0;
      end
    end
    ent_a = '{x: held_x, y: held_y, z: held_z, speed: held_speed,
              attrs: held_attrs, last: 1'b0};
    // The flushed point is the held point after this point's update.
    ent_b = '{x: held_x_next, y: held_y_next, z: held_z_next, speed: held_speed_next,
              attrs: held_attrs_next, last: 1'b1};
    push_n = {1'b0, push_a} + {1'b0, push_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing    <= SPACING_RESET;
      spacing_sq <= SPACING_SQ_RESET;
      in_valid   <= 1'b0;
      held_valid <= 1'b0;
      held_x     <= '0;
      held_y     <= '0;
      held_z     <= '0;
      held_speed <= '0;
      held_attrs <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (cfg_wr_en) begin
        spacing    <= cfg_wr_data;
        spacing_sq <= cfg_wr_data * cfg_wr_data;
      end
      if (in_fire) begin
        in_valid <= 1'b1;
      end else if (proc_fire) begin
        in_valid <= 1'b0;
      end
      held_valid <= held_valid_next;
      held_x     <= held_x_next;
      held_y     <= held_y_next;
      held_z     <= held_z_next;
      held_speed <= held_speed_next;
      held_attrs <= held_attrs_next;
      wr_ptr <= wr_ptr + PTR_BITS'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_BITS'(push_n) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_x     <= points.pos_x;
      in_y     <= points.pos_y;
      in_z     <= points.pos_z;
      in_speed <= points.speed;
      in_attrs <= points.attrs;
      in_last  <= points.last_point;
    end
    if (push_a) begin
      fifo[wr_ptr] <= ent_a;
    end
    if (push_b) begin
      fifo[wr_ptr + PTR_BITS'(push_a)] <= ent_b;
    end
  end

  assign results.valid     = (count != '0);
  assign results.out_x     = fifo[rd_ptr].x;
  assign results.out_y     = fifo[rd_ptr].y;
  assign results.out_z     = fifo[rd_ptr].z;
  assign results.out_speed = fifo[rd_ptr].speed;
  assign results.out_attrs = fifo[rd_ptr].attrs;
  assign results.out_last  = fifo[rd_ptr].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FIFO_DEPTH))
    else $error("result queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CNT_BITS'($past(push_n)) - CNT_BITS'($past(pop)))
    else $error("result queue count out of step with pushes and pops");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    proc_fire && in_last |=> !held_valid)
    else $error("held point survived a last point");

  a_first_holds: assert property (@(posedge clk) disable iff (rst)
    proc_fire && !held_valid && !in_last |=> held_valid && push_n == 2'd0 ||
    held_valid)
    else $error("first point of a path was not held");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && !proc_fire |=> in_valid && $stable(in_x) && $stable(in_last))
    else $error("waiting point lost from the input stage");
endmodule

// ===== bench/npmf_checker.sv =====
// ----------------------------------------------------------------------------
// npmf_checker
// Watches the point and result channels of the near point merge filter,
// predicts every kept point from the accepted input words and the spacing
// writes, and compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module npmf_checker import npmf_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [SPACING_BITS-1:0] cfg_wr_data,
  npmf_point_if                   points,
  npmf_result_if                  results,
  output int                      mismatch_count,
  output int                      words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic signed [SPEED_BITS-1:0] speed;
    logic [ATTR_BITS-1:0]         attrs;
    logic                         last;
  } kept_point_t;

  logic [SPACING_BITS-1:0] spacing;
  kept_point_t             held;
  logic                    held_valid;
  kept_point_t             kept_q[$];
  int                      mismatches = 0;
  int                      due_count = 0;

  assign mismatch_count = mismatches;
  assign words_due      = due_count;

  // Far when either offset alone exceeds the spacing, else when the squared
  // distance does. Equal distance merges.
  function automatic logic is_far(input logic signed [COORD_BITS-1:0] px,
                                  input logic signed [COORD_BITS-1:0] py);
    longint          dx;
    longint          dy;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned lim;
    dx  = longint'(px) - longint'(held.x);
    dy  = longint'(py) - longint'(held.y);
    ax  = (dx < 0) ? longint'(-dx) : dx;
    ay  = (dy < 0) ? longint'(-dy) : dy;
    lim = longint'(spacing);
    if (ax > lim || ay > lim) begin
      return 1'b1;
    end
    return (ax * ax + ay * ay) > (lim * lim);
  endfunction

  task automatic merge_point();
    kept_point_t incoming;
    incoming = '{points.pos_x, points.pos_y, points.pos_z, points.speed,
                 points.attrs, 1'b0};
    if (!held_valid) begin
      held       = incoming;
      held_valid = 1'b1;
    end else if (is_far(incoming.x, incoming.y)) begin
      kept_q = {kept_q, held};
      held = incoming;
    end else if (incoming.speed < held.speed) begin
      held.speed = incoming.speed;
    end
    if (points.last_point) begin
      held.last  = 1'b1;
      kept_q = {kept_q, held};
      held.last  = 1'b0;
      held_valid = 1'b0;
    end
  endtask

  task automatic check_word();
    kept_point_t got;
    kept_point_t want;
    got = '{results.out_x, results.out_y, results.out_z, results.out_speed,
            results.out_attrs, results.out_last};
    if (kept_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected kept point x=%0d y=%0d z=%0d speed=%0d attrs=%h last=%0b",
                 $realtime, got.x, got.y, got.z, got.speed, got.attrs, got.last);
      end
    end else begin
      want = kept_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: kept point mismatch (expected / actual)", $realtime);
          $display("  x     %0d / %0d", want.x, got.x);
          $display("  y     %0d / %0d", want.y, got.y);
          $display("  z     %0d / %0d", want.z, got.z);
          $display("  speed %0d / %0d", want.speed, got.speed);
          $display("  attrs %h / %h", want.attrs, got.attrs);
          $display("  last  %0b / %0b", want.last, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      spacing    = SPACING_RESET;
      held       = '0;
      held_valid = 1'b0;
      kept_q.delete();
    end else begin
      // A result word never stems from a point accepted at the same edge.
      if (results.valid && results.ready) begin
        check_word();
      end
      if (points.valid && points.ready) begin
        merge_point();
      end
      if (cfg_wr_en) begin
        spacing = cfg_wr_data;
      end
    end
    due_count = kept_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the near point merge filter: directed paths around the merge
// boundary and the field extremes, then random paths under several spacings
// with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb import npmf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS  = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 200;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [SPACING_BITS-1:0] cfg_wr_data;
  int                      mismatch_count;
  int                      words_due;
  int                      points_sent = 0;
  bit                      idle_on = 1'b1;
  bit                      hold_request = 1'b0;

  npmf_point_if  #(.COORD_BITS(COORD_BITS)) pt_if ();
  npmf_result_if #(.COORD_BITS(COORD_BITS)) res_if ();

  near_point_merge_filter #(.COORD_BITS(COORD_BITS)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .points      (pt_if),
    .results     (res_if)
  );

  npmf_checker #(.COORD_BITS(COORD_BITS)) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .points         (pt_if),
    .results        (res_if),
    .mismatch_count (mismatch_count),
    .words_due      (words_due)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #5ms;
    $display("near_point_merge_filter regression: fail");
    $finish;
  end

  // Result side: random back-pressure, plus one long stall on request.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_if.ready <= !idle_on || ($urandom_range(99) >= 21);
    end
  end

  // Valid stays high from one word to the next unless an idle gap is drawn.
  task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                            input logic signed [COORD_BITS-1:0] py,
                            input logic signed [COORD_BITS-1:0] pz,
                            input logic signed [SPEED_BITS-1:0] spd,
                            input logic [ATTR_BITS-1:0]         tag,
                            input logic                         fin);
    if (idle_on && $urandom_range(99) < 21) begin
      pt_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 21);
    end
    pt_if.valid      <= 1'b1;
    pt_if.pos_x      <= px;
    pt_if.pos_y      <= py;
    pt_if.pos_z      <= pz;
    pt_if.speed      <= spd;
    pt_if.attrs      <= tag;
    pt_if.last_point <= fin;
    @(posedge clk);
    while (!pt_if.ready) @(posedge clk);
    points_sent++;
  endtask

  // The spacing only changes with the filter drained and quiet.
  task automatic set_spacing(input logic [SPACING_BITS-1:0] value);
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A random walk whose steps straddle the spacing, with the odd jump anywhere.
  task automatic send_path(input int len, input int lim);
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    int                           pick;
    int                           span;
    int                           k;
    cx = COORD_BITS'($urandom);
    cy = COORD_BITS'($urandom);
    for (k = 0; k < len; k++) begin
      if (k > 0) begin
        pick = int'($urandom_range(99));
        if (pick < 85) begin
          span = (pick < 40) ? lim / 2 : ((pick < 70) ? lim + 1 : 2 * lim + 2);
          cx   = cx + COORD_BITS'(int'($urandom_range(2 * span)) - span);
          cy   = cy + COORD_BITS'(int'($urandom_range(2 * span)) - span);
        end else begin
          cx = COORD_BITS'($urandom);
          cy = COORD_BITS'($urandom);
        end
      end
      send_point(cx, cy, COORD_BITS'($urandom), SPEED_BITS'($urandom), $urandom,
                 k == len - 1);
    end
  endtask

  initial begin
    int ph;
    int lim;
    int target;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    pt_if.valid      = 1'b0;
    pt_if.pos_x      = '0;
    pt_if.pos_y      = '0;
    pt_if.pos_z      = '0;
    pt_if.speed      = '0;
    pt_if.attrs      = '0;
    pt_if.last_point = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset spacing of 10 mm.
    // A lone point that is also the last one.
    send_point(5, -5, 1, 100, $urandom, 1'b1);
    // Merges inside, on the circle, and far by one offset or by the diagonal.
    send_point(0, 0, 7, 500, $urandom, 1'b0);
    send_point(3, 4, 8, 300, $urandom, 1'b0);
    send_point(6, 8, 9, 400, $urandom, 1'b0);
    send_point(11, 0, 10, 200, $urandom, 1'b0);
    send_point(18, 8, 11, -50, $urandom, 1'b0);
    send_point(18, -2, 12, -24'sd8388608, $urandom, 1'b0);
    send_point(18, -2, 13, 24'sd8388607, $urandom, 1'b1);
    // Field extremes; a far point that is last releases two words.
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 24'sd8388607,
               32'hffffffff, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 32'sh7fffffff, -24'sd8388608,
               32'h0, 1'b1);
    send_point(32'sh80000000, 0, 0, 0, $urandom, 1'b0);
    send_point(32'sh8000000a, 0, 0, 1, $urandom, 1'b0);
    send_point(32'sh8000000a, 1, 0, -1, $urandom, 1'b1);

    // Zero spacing: only the exact position merges.
    set_spacing(16'd0);
    send_point(100, 100, 3, 20, $urandom, 1'b0);
    send_point(100, 100, 4, 10, $urandom, 1'b0);
    send_point(100, 101, 5, 30, $urandom, 1'b1);

    // Widest spacing.
    set_spacing(16'hffff);
    send_point(0, 0, 0, 5, $urandom, 1'b0);
    send_point(65535, 0, 0, 4, $urandom, 1'b0);
    send_point(-65535, 0, 0, 6, $urandom, 1'b0);
    send_point(65535, 1, 0, 3, $urandom, 1'b1);
    send_point(0, 0, 0, 9, $urandom, 1'b0);
    send_point(0, 65536, 0, 8, $urandom, 1'b1);

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          lim = 10;
        end
        1: begin
          lim = int'($urandom_range(1, 64));
        end
        2: begin
          lim = 0;
        end
        3: begin
          lim = 65535;
        end
        default: begin
          lim = int'($urandom_range(65535));
        end
      endcase
      set_spacing(SPACING_BITS'(lim));
      idle_on = (ph != 3);
      // Keep offering words while the output is held off so the filter backs up.
      if (ph == 1) begin
        hold_request = 1'b1;
      end
      target = points_sent + PHASE_WORDS;
      while (points_sent < target) begin
        send_path(int'($urandom_range(1, 12)), lim);
      end
    end

    pt_if.valid <= 1'b0;
    idle_on = 1'b1;
    while (words_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("near_point_merge_filter regression: pass");
    end else begin
      $display("near_point_merge_filter regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/npmf_pkg.sv
sv/npmf_point_if.sv
sv/npmf_result_if.sv
sv/npmf_distance.sv
sv/near_point_merge_filter.sv
bench/npmf_checker.sv
bench/tb.sv
